// ----- src/hsc_pkg.sv -----
// package: types, constants, tables and tree helpers for the classifier
`default_nettype none
package hsc_pkg;
  localparam int CLASS_COUNT = 10;
  localparam int NODES = CLASS_COUNT - 1;
  localparam int Z_MAX = 24576;
  localparam int INV_ALPHA_SQ = 455;
  localparam int CW = 6;
  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int KW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

  typedef struct packed {
    logic signed [15:0] gate_mean;
    logic [15:0]        gate_variance;
    logic [5:0]         true_label;
    logic               last_gate;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  class_index;
    logic [15:0] class_prob;
    logic [5:0]  predicted_class;
    logic        is_error;
    logic        last_class;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_DIV, ST_PHI, ST_PROD, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;      // latch input item, start sqrt
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic phi_do;    // write gate probability
    logic prod_start;
    logic prod_step;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic prod_done;   // all classes done
    logic store_gate;  // current gate index in range
    logic last;
  } sts_t;

  function automatic logic [16:0] phi_tab(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0: v = 17'd32768;  5'd1: v = 17'd39237;  5'd2: v = 17'd45316;
      5'd3: v = 17'd50684;  5'd4: v = 17'd55138;  5'd5: v = 17'd58612;
      5'd6: v = 17'd61158;  5'd7: v = 17'd62911;  5'd8: v = 17'd64045;
      5'd9: v = 17'd64735;  5'd10: v = 17'd65129; 5'd11: v = 17'd65341;
      5'd12: v = 17'd65448; 5'd13: v = 17'd65498; 5'd14: v = 17'd65521;
      5'd15: v = 17'd65530; 5'd16: v = 17'd65534; 5'd17: v = 17'd65535;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  // phi of a nonnegative magnitude (up to 15 bits), 32768..65536
  function automatic logic [16:0] phi_mag(input logic [14:0] mag);
    logic [4:0] i;
    logic [9:0] fr;
    logic [16:0] a, b;
    logic [27:0] t;
    if (mag >= 15'(Z_MAX)) return 17'd65536;
    i = mag[14:10];
    fr = mag[9:0];
    a = phi_tab(i);
    b = phi_tab(i + 5'd1);
    t = 28'(b - a) * 28'(fr) + 28'd512;
    return a + 17'(t >> 10);
  endfunction

  // bias search at elaboration
  // least z with phi(z) >= round(left * 65536 / span)
  function automatic int node_bias(input int left, input int span);
    int x, lo, hi, mid;
    x = left * 65536 + (span >> 1);
    lo = 0;
    hi = Z_MAX;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if ((int'(phi_mag(15'(mid))) + 1) * span > x) hi = mid;
      else lo = mid + 1;
    end
    return (lo + 1) / 3;
  endfunction

  // per node: span, bias
  function automatic int node_span(input int nd);
    int s, e, n, l, node;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      s = 0; e = CLASS_COUNT; node = 0;
      while (e - s > 1 && node < NODES) begin
        n = e - s; l = (n + 1) / 2;
        if (node == nd) return n;
        if (c < s + l) begin e = s + l; node = node + 1; end
        else begin s = s + l; node = node + l; end
      end
    end
    return 2;
  endfunction

  function automatic logic [NODES*16-1:0] bias_table();
    logic [NODES*16-1:0] r;
    r = '0;
    for (int k = 0; k < NODES; k++)
      r[k*16 +: 16] = 16'(node_bias((node_span(k) + 1) / 2, node_span(k)));
    return r;
  endfunction

  localparam logic [NODES*16-1:0] BIAS_ROM = bias_table();
endpackage
`default_nettype wire

// ----- src/hsc_ctrl.sv -----
// controller state machine of the classifier
`default_nettype none
module hsc_ctrl import hsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic out_busy,
  output cmd_t      cmd,
  input  sts_t      sts
);
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && !out_busy) state_nxt = ST_SQRT;
      ST_SQRT: if (sts.sqrt_done) state_nxt = sts.store_gate ? ST_DIV : ST_PHI;
      ST_DIV:  if (sts.div_done) state_nxt = ST_PHI;
      ST_PHI:  state_nxt = sts.last ? ST_PROD : ST_IDLE;
      ST_PROD: if (sts.prod_done) state_nxt = ST_EMIT;
      ST_EMIT: if (!out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        // no new item while results stream
        in_stall = out_busy;
        cmd.load = in_valid && !out_busy;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cmd.div_start = sts.sqrt_done;
      end
      ST_DIV: cmd.div_step = 1'b1;
      ST_PHI: begin
        cmd.phi_do = 1'b1;
        cmd.prod_start = sts.last;
      end
      ST_PROD: cmd.prod_step = 1'b1;
      ST_EMIT: cmd.emit_load = !out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ----- src/hsc_dp.sv -----
// datapath: sqrt, divide, phi, path products and argmax, result sequencing
`default_nettype none
module hsc_dp import hsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic use_bias,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  wire logic out_stall,
  output logic      out_valid,
  output out_item_t out_item,
  output logic      out_busy
);
  logic [CW-1:0] gcnt_r;
  logic [CW-1:0] label_r;
  logic          last_r;
  logic          neg_r;
  logic [15:0]   mag_r;
  logic [29:0]   rad_r;
  logic [14:0]   root_r;
  logic [3:0]    sq_cnt_r;
  logic [28:0]   rem_r;
  logic [17:0]   quo_r;
  logic [4:0]    dv_cnt_r;
  logic [15:0]   gp_r [NODES];
  logic [15:0]   cp_r [CLASS_COUNT];
  logic [KW-1:0] cls_r;
  logic [16:0]   acc_r;
  logic [KW:0]   ps_r, pe_r, pnode_r;
  logic [5:0]    best_r;
  logic [15:0]   bestp_r;
  logic          prod_done_r;
  logic [KW-1:0] ecnt_r;
  logic          emitting_r;
  logic [5:0]    emit_best_r;
  logic          emit_err_r;

  // radix-2 sqrt, one result bit per cycle
  logic [29:0] trial;
  always_comb begin
    trial = {rem_r[27:0], rad_r[29:28]} - 30'({root_r, 2'b01});
  end

  // division step
  logic [29:0] dtrial;
  assign dtrial = {rem_r[28:0], rad_r[29]} - 30'(root_r);

  logic signed [17:0] num;
  always_comb begin
    num = 18'(in_item.gate_mean) +
          ((use_bias && gcnt_r < CW'(NODES)) ?
           18'(signed'({2'b00, BIAS_ROM[gcnt_r[NW-1:0] * 16 +: 16]})) : 18'sd0);
  end

  assign sts.store_gate = gcnt_r < CW'(NODES);
  assign sts.sqrt_done = sq_cnt_r == 4'd15;
  assign sts.div_done = dv_cnt_r == 5'd28;
  assign sts.last = last_r;
  assign sts.prod_done = prod_done_r;

  // gate probability
  logic [14:0] qsat;
  logic [16:0] praw, pfin;
  always_comb begin
    qsat = (quo_r > 18'(Z_MAX)) ? 15'(Z_MAX) : quo_r[14:0];
    praw = phi_mag(qsat);
    pfin = neg_r ? 17'd65536 - praw : praw;
    if (pfin > 17'd65535) pfin = 17'd65535;
  end

  // product step
  logic [KW:0]   plen, pl;
  logic [15:0]   gsel;
  logic [16:0]   fac;
  logic [33:0]   mul;
  logic          go_left;
  always_comb begin
    plen = pe_r - ps_r;
    pl = (plen + 1'b1) >> 1;
    gsel = gp_r[NW'(pnode_r)];
    go_left = ({1'b0, cls_r} < ps_r + pl);
    fac = go_left ? {1'b0, gsel} : 17'd65536 - {1'b0, gsel};
    mul = 34'(acc_r) * 34'(fac) + 34'd32768;
  end
  logic path_end;
  assign path_end = (plen <= 1) || (pnode_r >= (KW+1)'(NODES));
  logic [15:0] cls_prob;
  assign cls_prob = (acc_r > 17'd65535) ? 16'hffff : acc_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcnt_r <= '0;
      label_r <= '0;
      best_r <= '0;
      bestp_r <= '0;
      emitting_r <= 1'b0;
      prod_done_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        last_r <= in_item.last_gate;
        label_r <= in_item.true_label;
        neg_r <= num < 0;
        mag_r <= num < 0 ? 16'(-num) : 16'(num);
        rad_r <= 30'({14'd0, in_item.gate_variance} + 30'(INV_ALPHA_SQ)) << 12;
        root_r <= '0;
        rem_r <= '0;
        sq_cnt_r <= '0;
      end
      if (cmd.sqrt_step && !sts.sqrt_done) begin
        rad_r <= rad_r << 2;
        sq_cnt_r <= sq_cnt_r + 4'd1;
        if (!trial[29]) begin
          rem_r <= 29'(trial);
          root_r <= {root_r[13:0], 1'b1};
        end else begin
          rem_r <= {rem_r[26:0], rad_r[29:28]};
          root_r <= {root_r[13:0], 1'b0};
        end
      end
      if (cmd.div_start) begin
        rem_r <= '0;
        rad_r <= {mag_r, 12'd0, 2'd0};
        quo_r <= '0;
        dv_cnt_r <= '0;
      end
      if (cmd.div_step && !sts.div_done) begin
        dv_cnt_r <= dv_cnt_r + 5'd1;
        rad_r <= rad_r << 1;
        // quotient sticks once past the saturation point
        if (!dtrial[29]) begin
          rem_r <= dtrial[28:0];
          quo_r <= (quo_r > 18'(Z_MAX)) ? quo_r : {quo_r[16:0], 1'b1};
        end else begin
          rem_r <= {rem_r[27:0], rad_r[29]};
          quo_r <= (quo_r > 18'(Z_MAX)) ? quo_r : {quo_r[16:0], 1'b0};
        end
      end
      if (cmd.phi_do) begin
        if (sts.store_gate) gp_r[NW'(gcnt_r)] <= pfin[15:0];
        gcnt_r <= last_r ? '0 : ((gcnt_r != 6'd63) ? gcnt_r + 6'd1 : gcnt_r);
      end
      if (cmd.prod_start) begin
        cls_r <= '0;
        acc_r <= 17'd65536;
        ps_r <= '0;
        pe_r <= (KW+1)'(CLASS_COUNT);
        pnode_r <= '0;
        prod_done_r <= 1'b0;
        best_r <= '0;
        bestp_r <= '0;
      end
      if (cmd.prod_step && !prod_done_r) begin
        if (!path_end) begin
          acc_r <= 17'(mul >> 16);
          if (go_left) begin
            pe_r <= ps_r + pl;
            pnode_r <= pnode_r + 1'b1;
          end else begin
            ps_r <= ps_r + pl;
            pnode_r <= pnode_r + pl;
          end
        end else begin
          cp_r[cls_r] <= cls_prob;
          if (cls_r == '0 || cls_prob > bestp_r) begin
            bestp_r <= cls_prob;
            best_r <= 6'(cls_r);
          end
          acc_r <= 17'd65536;
          ps_r <= '0;
          pe_r <= (KW+1)'(CLASS_COUNT);
          pnode_r <= '0;
          if (cls_r == KW'(CLASS_COUNT - 1)) prod_done_r <= 1'b1;
          else cls_r <= cls_r + 1'b1;
        end
      end
      if (cmd.emit_load) begin
        emitting_r <= 1'b1;
        ecnt_r <= '0;
        emit_best_r <= best_r;
        emit_err_r <= (label_r >= 6'(CLASS_COUNT)) || (best_r != label_r);
        prod_done_r <= 1'b0;
      end else if (emitting_r && !out_stall) begin
        if (ecnt_r == KW'(CLASS_COUNT - 1)) emitting_r <= 1'b0;
        else ecnt_r <= ecnt_r + 1'b1;
      end
    end
  end

  assign out_busy = emitting_r;
  assign out_valid = emitting_r;
  always_comb begin
    out_item.class_index = 6'(ecnt_r);
    out_item.class_prob = cp_r[ecnt_r];
    out_item.predicted_class = emit_best_r;
    out_item.is_error = emit_err_r;
    out_item.last_class = ecnt_r == KW'(CLASS_COUNT - 1);
  end
endmodule
`default_nettype wire

// ----- src/hierarchical_softmax_classify.sv -----
// top level of the hierarchical softmax classifier
// Channels: in_valid/in_stall carry one gate item (in_item); out_valid/out_stall carry
// class results (out_item). cfg_we/cfg_wdata write the prior-bias enable (reset 1).
// Each gate item is finished before the next one is accepted; after acceptance it takes a
// 15-step bit-serial square root of the denominator, a 28-step restoring divide and a
// phi lookup; gates past the last node skip the divide. On the last_gate item the block
// then forms every class probability with one 17x17 multiply per tree level, one level a
// cycle, and then streams one result per class, one per cycle while out_stall is low, in
// class order.
// While results stream no new item is taken; a stall on out_stall holds the current
// result. Synchronous reset clears the gate counter, argmax state and the controller;
// gate probability storage is undefined until written.
`default_nettype none
module hierarchical_softmax_classify import hsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_item,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);
  cmd_t cmd;
  sts_t sts;
  logic out_busy;
  logic use_bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) use_bias_r <= 1'b1;
    else if (cfg_we) use_bias_r <= cfg_wdata;
  end

  hsc_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .out_busy, .cmd, .sts);

  hsc_dp u_dp (.clk, .rst_n, .use_bias(use_bias_r), .in_item, .cmd, .sts,
    .out_stall, .out_valid, .out_item, .out_busy);

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted during output");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_item.last_class) |=> !out_valid)
    else $error("results continue past last class");
  a_pred_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid)) |-> $stable(out_item.predicted_class))
    else $error("prediction changed within sample");
endmodule
`default_nettype wire

// ----- tb/sv/tb_hierarchical_softmax_classify.sv -----
// testbench for the hierarchical softmax classifier: gate items in, class results checked
`default_nettype none
module tb_hierarchical_softmax_classify import hsc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  always #2 clk = ~clk;

  hierarchical_softmax_classify DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // own copy of the classifier state
  logic        prior_on;
  logic [15:0] gate_p[NODES];
  int          gates_seen;

  in_item_t  pending_items[$];
  out_item_t expected_classes[$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int classes_seen = 0;
  bit idle_free = 1'b0;
  bit in_taken = 1'b0;

  const logic [16:0] phi_points[25] = '{32768, 39237, 45316, 50684, 55138, 58612,
    61158, 62911, 64045, 64735, 65129, 65341, 65448, 65498, 65521, 65530, 65534,
    65535, 65536, 65536, 65536, 65536, 65536, 65536, 65536};

  function automatic int phi_of(int z);
    int m, v, i, fr;
    m = (z < 0) ? -z : z;
    if (m >= Z_MAX) v = 65536;
    else begin
      i = m >> 10;
      fr = m & 1023;
      v = phi_points[i] + (((phi_points[i + 1] - phi_points[i]) * fr + 512) >> 10);
    end
    return (z < 0) ? 65536 - v : v;
  endfunction

  function automatic int sqrt_floor(longint x);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= x) r++;
    return int'(r);
  endfunction

  // prior bias of a node: inverse phi of left share, divided by three
  function automatic int prior_of(int left, int span);
    int t, lo, hi, mid;
    t = (left * 65536 + span / 2) / span;
    lo = 0;
    hi = Z_MAX;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (phi_of(mid) >= t) hi = mid;
      else lo = mid + 1;
    end
    return (lo + 1) / 3;
  endfunction

  int prior_tab[NODES];

  initial begin
    int s, e, nd, l;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      s = 0; e = CLASS_COUNT; nd = 0;
      while (e - s > 1 && nd < NODES) begin
        l = (e - s + 1) / 2;
        prior_tab[nd] = prior_of(l, e - s);
        if (c < s + l) begin e = s + l; nd++; end
        else begin s = s + l; nd += l; end
      end
    end
  end

  task automatic classify_item(in_item_t it);
    int num, d, q, p, s, e, nd, l, best, bestp;
    longint acc;
    logic err;
    out_item_t r;
    int probs[CLASS_COUNT];
    if (gates_seen < NODES) begin
      num = int'(it.gate_mean) + (prior_on ? prior_tab[gates_seen] : 0);
      d = sqrt_floor((longint'(it.gate_variance) + INV_ALPHA_SQ) * 4096);
      q = int'(((longint'((num < 0) ? -num : num)) * 4096) / d);
      if (q > Z_MAX) q = Z_MAX;
      p = phi_of((num < 0) ? -q : q);
      if (p > 65535) p = 65535;
      gate_p[gates_seen] = 16'(p);
    end
    if (gates_seen < 63) gates_seen++;
    if (!it.last_gate) return;
    best = 0;
    bestp = 0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      acc = 65536; s = 0; e = CLASS_COUNT; nd = 0;
      while (e - s > 1 && nd < NODES) begin
        l = (e - s + 1) / 2;
        if (c < s + l) begin
          acc = (acc * gate_p[nd] + 32768) >> 16; e = s + l; nd++;
        end else begin
          acc = (acc * (65536 - gate_p[nd]) + 32768) >> 16; s = s + l; nd += l;
        end
      end
      if (acc > 65535) acc = 65535;
      probs[c] = int'(acc);
      if (c == 0 || acc > bestp) begin bestp = int'(acc); best = c; end
    end
    err = (it.true_label >= CLASS_COUNT) || (best != it.true_label);
    for (int c = 0; c < CLASS_COUNT; c++) begin
      r.class_index = 6'(c);
      r.class_prob = 16'(probs[c]);
      r.predicted_class = 6'(best);
      r.is_error = err;
      r.last_class = (c == CLASS_COUNT - 1);
      expected_classes.insert(expected_classes.size(), r);
    end
    gates_seen = 0;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        // accepted at the last rising edge
        classify_item(in_item);
        items_sent++;
        void'(pending_items.pop_front());
      end
      if (in_valid && !in_taken) begin
        // hold stalled item
      end else if (pending_items.size() > 0 && (idle_free || $urandom_range(99) >= 10)) begin
        in_item <= pending_items[0];
        in_valid <= 1'b1;
      end else in_valid <= 1'b0;
      out_stall <= !idle_free && ($urandom_range(99) < 10);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      classes_seen++;
      if (expected_classes.size() == 0) report_mismatch("unexpected result index", out_item.class_index, -1);
      else begin
        w = expected_classes.pop_front();
        if (out_item.class_index != w.class_index)
          report_mismatch("class_index", out_item.class_index, w.class_index);
        if (out_item.class_prob != w.class_prob)
          report_mismatch("class_prob", out_item.class_prob, w.class_prob);
        if (out_item.predicted_class != w.predicted_class)
          report_mismatch("predicted_class", out_item.predicted_class, w.predicted_class);
        if (out_item.is_error != w.is_error)
          report_mismatch("is_error", out_item.is_error, w.is_error);
        if (out_item.last_class != w.last_class)
          report_mismatch("last_class", out_item.last_class, w.last_class);
      end
    end
  end

  function automatic in_item_t gate_item(int mean, int variance, int label, bit last);
    in_item_t it;
    it.gate_mean = 16'(mean);
    it.gate_variance = 16'(variance);
    it.true_label = 6'(label);
    it.last_gate = last;
    return it;
  endfunction

  function automatic int rand_mean();
    case ($urandom_range(3))
      0: return int'($urandom_range(65535)) - 32768;
      1: return int'($urandom_range(8191)) - 4096;
      2: return ($urandom_range(1)) ? 32767 : -32768;
      default: return int'($urandom_range(1023)) - 512;
    endcase
  endfunction

  function automatic int rand_var();
    case ($urandom_range(2))
      0: return $urandom_range(65535);
      1: return $urandom_range(2047);
      default: return ($urandom_range(1)) ? 65535 : 0;
    endcase
  endfunction

  function automatic int rand_label();
    return ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(CLASS_COUNT - 1);
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_classes.size() > 0) @(posedge clk);
    // gates without a result may still be in flight
    repeat (80) @(posedge clk);
  endtask

  task automatic write_prior(logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    prior_on = v;
  endtask

  task automatic queue_sample(int ngates);
    for (int g = 0; g < ngates; g++)
      pending_items.insert(pending_items.size(),
                           gate_item(rand_mean(), rand_var(), rand_label(), g == ngates - 1));
  endtask

  initial begin
    int mode;
    prior_on = 1'b1;
    gates_seen = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes with prior bias on (reset value)
    for (int g = 0; g < NODES; g++)
      pending_items.insert(pending_items.size(),
                           gate_item((g % 2) ? 32767 : -32768, (g % 3) ? 0 : 65535,
                                     3, g == NODES - 1));
    for (int g = 0; g < NODES; g++)
      pending_items.insert(pending_items.size(), gate_item(0, 0, 63, g == NODES - 1));
    wait_drained();
    write_prior(1'b0);
    // zero input without bias gives ties everywhere; extra gates then a sample
    for (int g = 0; g < NODES + 2; g++)
      pending_items.insert(pending_items.size(),
                           gate_item(0, 0, CLASS_COUNT, g == NODES + 1));
    // early last gate keeps earlier gate probabilities
    pending_items.insert(pending_items.size(), gate_item(-1, 65535, 0, 1'b0));
    pending_items.insert(pending_items.size(), gate_item(4096, 455, 5, 1'b1));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_prior(ph % 2 == 0);
      idle_free = (ph == 2);
      while (items_sent + pending_items.size() < 45 * (ph + 1)) begin
        mode = $urandom_range(9);
        if (mode < 7) queue_sample(NODES);
        else if (mode < 8) queue_sample(NODES + $urandom_range(1, 3));
        else queue_sample($urandom_range(1, NODES - 1));
      end
      wait_drained();
    end
    idle_free = 1'b0;

    $display("sent %0d gate items, checked %0d class results, prior bias on and off",
             items_sent, classes_seen);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

// ----- hierarchical_softmax_classify.f -----
src/hsc_pkg.sv
src/hsc_ctrl.sv
src/hsc_dp.sv
src/hierarchical_softmax_classify.sv
tb/sv/tb_hierarchical_softmax_classify.sv
